// ===== rtl/tstc_pkg.sv =====
// Shared types and constants for the sequential turn-signal controller.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package tstc_pkg;

  localparam int unsigned BTN_W  = 5;
  localparam int unsigned LED_W  = 16;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned STEP_W = 3;

  localparam logic [BTN_W-1:0]  MASK_LEFT   = 5'b00010;
  localparam logic [BTN_W-1:0]  MASK_RIGHT  = 5'b01000;
  localparam logic [BTN_W-1:0]  MASK_HAZARD = 5'b10000;
  localparam logic [TICK_W-1:0] TICK_RESET  = 32'd7500000;

  // Sweep limits: six lit steps, then three dark ticks in OFF.
  localparam logic [STEP_W-1:0] STEP_ON_LAST  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_OFF_LAST = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MAX      = 3'd7;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_L_ON  = 3'd1,
    MODE_L_OFF = 3'd2,
    MODE_R_ON  = 3'd3,
    MODE_R_OFF = 3'd4,
    MODE_H_ON  = 3'd5,
    MODE_H_OFF = 3'd6
  } mode_t;

endpackage

`default_nettype wire

// ===== rtl/tstc_if.sv =====
// Valid/ready channel interfaces: button beats, LED beats, config writes.
// Depends on tstc_pkg for the payload widths.
`default_nettype none

interface tstc_in_if;
  logic                           valid;
  logic                           ready;
  logic [tstc_pkg::BTN_W-1:0]     buttons;
  modport source (output valid, output buttons, input ready);
  modport sink   (input valid, input buttons, output ready);
endinterface

interface tstc_out_if;
  logic                           valid;
  logic                           ready;
  logic [tstc_pkg::LED_W-1:0]     leds;
  modport source (output valid, output leds, input ready);
  modport sink   (input valid, input leds, output ready);
endinterface

interface tstc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tstc_pkg::TICK_W-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tstc_core.sv =====
// Controller state: press one-shot, mode FSM, LED pattern and tick divider.
// Advances once per beat on step; depends on tstc_pkg.
`default_nettype none

module tstc_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [tstc_pkg::BTN_W-1:0]    buttons,
  input  wire logic [tstc_pkg::TICK_W-1:0]   tick_period,
  output logic      [tstc_pkg::LED_W-1:0]    leds_nxt
);

  tstc_pkg::mode_t                  mode_r, mode_nxt;
  logic [tstc_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                             wait_r, wait_nxt;
  logic                             ret_r, ret_nxt;
  logic                             held_r, held_nxt;
  logic [tstc_pkg::LED_W-1:0]       pat_r, pat_nxt;
  logic [tstc_pkg::TICK_W-1:0]      div_r, div_nxt;

  function automatic logic [tstc_pkg::LED_W-1:0] left_bit(input logic [2:0] s);
    logic [tstc_pkg::LED_W-1:0] v;
    v = '0;
    if (s <= tstc_pkg::STEP_ON_LAST) v = 16'h0400 << s;
    return v;
  endfunction

  function automatic logic [tstc_pkg::LED_W-1:0] right_bit(input logic [2:0] s);
    logic [tstc_pkg::LED_W-1:0] v;
    v = '0;
    if (s <= tstc_pkg::STEP_ON_LAST) v = 16'h0020 >> s;
    return v;
  endfunction

  logic [tstc_pkg::BTN_W-1:0]  nb;
  logic [tstc_pkg::BTN_W-1:0]  mask;
  logic [tstc_pkg::LED_W-1:0]  lit;
  tstc_pkg::mode_t             on_mode, off_mode;
  logic                        run_mode, pressed, was_active, active;
  logic [tstc_pkg::TICK_W:0]   div_inc;

  // Decode the run the current mode belongs to
  always_comb begin
    on_mode  = tstc_pkg::MODE_IDLE;
    off_mode = tstc_pkg::MODE_IDLE;
    mask     = '0;
    lit      = '0;
    run_mode = 1'b1;
    unique case (mode_r) inside
      tstc_pkg::MODE_L_ON, tstc_pkg::MODE_L_OFF: begin
        on_mode  = tstc_pkg::MODE_L_ON;
        off_mode = tstc_pkg::MODE_L_OFF;
        mask     = tstc_pkg::MASK_LEFT;
        lit      = left_bit(step_r);
      end
      tstc_pkg::MODE_R_ON, tstc_pkg::MODE_R_OFF: begin
        on_mode  = tstc_pkg::MODE_R_ON;
        off_mode = tstc_pkg::MODE_R_OFF;
        mask     = tstc_pkg::MASK_RIGHT;
        lit      = right_bit(step_r);
      end
      tstc_pkg::MODE_H_ON, tstc_pkg::MODE_H_OFF: begin
        on_mode  = tstc_pkg::MODE_H_ON;
        off_mode = tstc_pkg::MODE_H_OFF;
        mask     = tstc_pkg::MASK_HAZARD;
        lit      = left_bit(step_r) | right_bit(step_r);
      end
      default: run_mode = 1'b0;
    endcase
  end

  // One-shot, mode FSM, then the tick divider
  always_comb begin
    mode_nxt = mode_r;
    step_nxt = step_r;
    wait_nxt = wait_r;
    ret_nxt  = ret_r;
    held_nxt = held_r;
    pat_nxt  = pat_r;
    div_nxt  = div_r;
    nb       = '0;
    pressed  = 1'b0;
    div_inc  = {1'b0, div_r} + 33'd1;

    if (!wait_r) begin
      // press one-shot
      if (!held_r) begin
        nb       = buttons;
        held_nxt = (buttons != '0);
      end else if (buttons == '0) begin
        held_nxt = 1'b0;
      end
      pressed = ((nb & mask) != '0);

      if (!run_mode) begin
        wait_nxt = 1'b0;
        pat_nxt  = '0;
        ret_nxt  = 1'b0;
        step_nxt = '0;
        if ((nb & tstc_pkg::MASK_LEFT) != '0)        mode_nxt = tstc_pkg::MODE_L_ON;
        else if ((nb & tstc_pkg::MASK_RIGHT) != '0)  mode_nxt = tstc_pkg::MODE_R_ON;
        else if ((nb & tstc_pkg::MASK_HAZARD) != '0) mode_nxt = tstc_pkg::MODE_H_ON;
        else                                         mode_nxt = tstc_pkg::MODE_IDLE;
      end else if (mode_r == on_mode) begin
        if (pressed) ret_nxt = 1'b1;
        if (!pressed && step_r > tstc_pkg::STEP_ON_LAST) begin
          mode_nxt = off_mode;
          wait_nxt = 1'b1;
        end else begin
          pat_nxt = pat_r | lit;
        end
      end else begin
        pat_nxt = '0;
        if (pressed || ret_r) mode_nxt = tstc_pkg::MODE_IDLE;
        if (!pressed && step_r > tstc_pkg::STEP_OFF_LAST) begin
          mode_nxt = on_mode;
          wait_nxt = 1'b1;
        end
      end
    end

    was_active = run_mode;
    active     = (mode_nxt != tstc_pkg::MODE_IDLE);

    // tick divider runs only across beats that stay in a run
    if (!active) begin
      div_nxt = '0;
    end else if (was_active) begin
      if (div_inc >= {1'b0, tick_period}) begin
        div_nxt = '0;
        if (wait_nxt) begin
          step_nxt = '0;
          wait_nxt = 1'b0;
        end else if (step_nxt != tstc_pkg::STEP_MAX) begin
          step_nxt = step_nxt + 3'd1;
        end
      end else begin
        div_nxt = div_inc[tstc_pkg::TICK_W-1:0];
      end
    end
  end

  assign leds_nxt = pat_nxt;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tstc_pkg::MODE_IDLE;
      step_r <= '0;
      wait_r <= 1'b0;
      ret_r  <= 1'b0;
      held_r <= 1'b0;
      pat_r  <= '0;
      div_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      step_r <= step_nxt;
      wait_r <= wait_nxt;
      ret_r  <= ret_nxt;
      held_r <= held_nxt;
      pat_r  <= pat_nxt;
      div_r  <= div_nxt;
    end
  end

  // Idle keeps the pattern, the divider and the wait flag cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == tstc_pkg::MODE_IDLE) |-> (pat_r == '0 && div_r == '0 && !wait_r))
    else $error("idle with live run state");

  // A beat taken while waiting leaves the LEDs alone
  a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && wait_r) |=> $stable(pat_r))
    else $error("LEDs changed while waiting for tick");

  // After a beat the divider is below the period it ran with, unless that was zero
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step && tick_period != '0) |=> (div_r < $past(tick_period)))
    else $error("tick divider out of range");

endmodule

`default_nettype wire

// ===== rtl/sequential_turn_signal_controller.sv =====
// Sequential turn-signal controller: one LED beat out for each button beat in.
// Path: button beat held in the input reg, its LED beat computed into the result reg.
// Throughput: one beat per cycle; a stalled LED side blocks input once both regs are full.
// The tick divider and all mode state live in tstc_core and advance once per beat.
// Reset (rst_n low, synchronous): idle mode, core LED pattern cleared, channels empty,
// tick_period back to 7500000.
`default_nettype none

module sequential_turn_signal_controller (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tstc_in_if.sink         in_ch,
  tstc_out_if.source      out_ch,
  tstc_cfg_if.sink        cfg_ch
);

  logic                          in_valid_r;
  logic [tstc_pkg::BTN_W-1:0]    in_buttons_r;
  logic                          out_valid_r;
  logic [tstc_pkg::LED_W-1:0]    out_leds_r;
  logic [tstc_pkg::TICK_W-1:0]   tick_period_r;
  logic [tstc_pkg::LED_W-1:0]    leds_nxt;
  logic                          adv;

  // Stage advances when the result register is free or being drained
  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.leds  = out_leds_r;
  assign cfg_ch.ready = 1'b1;

  tstc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .buttons     (in_buttons_r),
    .tick_period (tick_period_r),
    .leds_nxt    (leds_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_buttons_r <= in_ch.buttons;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_leds_r <= leds_nxt;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= tstc_pkg::TICK_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      tick_period_r <= cfg_ch.data;
    end
  end

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("computed beat not held in result register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_buttons_r)))
    else $error("pending button beat lost");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("channels not empty after reset");

endmodule

`default_nettype wire
